@@ rtl/rmlf_pkg.sv @@
// Shared types, constants and state encoding for the multi-line RANSAC fitter.
`timescale 1ns / 1ps

package rmlf_pkg;

    // One input point as it arrives on the input channel.
    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               last_point;
    } pt_in_t;

    // One detected line, or the closing "no line" record of a run.
    typedef struct packed {
        logic signed [47:0] line_slope;
        logic signed [47:0] line_intercept;
        logic [2:0]         line_number;
        logic               line_found;
        logic [8:0]         remaining_points;
        logic               last_result;
    } line_res_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_ITERATIONS = 2'd1;
    localparam logic [1:0] REG_SEED       = 2'd2;

    // Register reset values.
    localparam logic [15:0] THR_RESET  = 16'd128;
    localparam logic [9:0]  ITER_RESET = 10'd100;
    localparam logic [31:0] SEED_RESET = 32'd1;

    // Galois LFSR feedback taps.
    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    // Datapath unit widths.
    localparam int MUL_W  = 64;
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 24;

    // Saturation limits of a signed 48-bit value.
    localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_SEARCH, ST_ITER,
        ST_IDX1, ST_IDX1_W, ST_IDX2, ST_IDX2_W, ST_SKIP,
        ST_RD1, ST_RD2, ST_RD3,
        ST_SLOPE, ST_SLOPE_W, ST_ICPT, ST_ICPT_W,
        ST_MT, ST_MT_W, ST_RHS, ST_RHS_W,
        ST_SC_RD, ST_SC_LAT, ST_SC_MX, ST_SC_MX_W, ST_SC_SQ, ST_SC_SQ_W, ST_SC_END,
        ST_CMP_RD, ST_CMP_WR, ST_CMP_END, ST_EMIT
    } rmlf_state_t;

    // Magnitude of a signed 24-bit coordinate.
    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        logic [23:0] r;
        r = v[23] ? 24'(-v) : 24'(v);
        return r;
    endfunction

endpackage

@@ rtl/rmlf_mul.sv @@
// Sequential 64x64 unsigned multiplier built on one 32x32 partial product a cycle.
`timescale 1ns / 1ps

module rmlf_mul
    import rmlf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 done,
    output logic [2*MUL_W-1:0]   prod
);

    localparam int HW = MUL_W / 2;

    logic [MUL_W-1:0]   a_reg;
    logic [MUL_W-1:0]   b_reg;
    logic [MUL_W-1:0]   pp_reg;
    logic [2*MUL_W-1:0] acc_reg;
    logic [2:0]         step_reg;
    logic [1:0]         prev;
    logic               busy_reg;
    logic               done_reg;
    logic [HW-1:0]      a_half;
    logic [HW-1:0]      b_half;
    logic [2*MUL_W-1:0] pp_shift;

    // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
    always_comb begin
        a_half = step_reg[1] ? a_reg[MUL_W-1:HW] : a_reg[HW-1:0];
        b_half = step_reg[0] ? b_reg[MUL_W-1:HW] : b_reg[HW-1:0];
        prev   = 2'(step_reg - 3'd1);
        case (prev)
            2'd0:    pp_shift = {{MUL_W{1'b0}}, pp_reg};
            2'd3:    pp_shift = {pp_reg, {MUL_W{1'b0}}};
            default: pp_shift = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
        endcase
    end

    // Product of one step is registered, then added in the next step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg != 3'd4) begin
                pp_reg <= a_half * b_half;
            end
            if (step_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/rmlf_div.sv @@
// Restoring unsigned divider, one quotient bit a cycle.
`timescale 1ns / 1ps

module rmlf_div
    import rmlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder
);

    localparam int SW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] d_reg;
    logic [SW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic              ge;
    logic [DIV_DW:0]   rem_calc;

    // One trial subtraction per cycle.
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_NW-1]};
        ge       = shifted >= {1'b0, d_reg};
        rem_calc = ge ? (shifted - {1'b0, d_reg}) : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SW'(DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_calc[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/ransac_multi_line_fit.sv @@
// Top level: point memory, inlier mask memory and the sequential RANSAC controller.
//
//  Channel   Ports                       Moves
//  input     s_valid s_ready s_data      one point per transaction
//  result    m_valid m_ready m_data      one line (or "no line") per transaction
//  config    cfg_we cfg_index cfg_data   one register write per cycle, no wait
//
// Points load at one per cycle while idle. After the point marked last_point the block runs
// detection and takes no input; each candidate pair costs two modulo divisions, one slope
// division and 64-bit multiplies (three per pair, two per point), plus a compaction pass
// over the points per found line.
// A stalled result holds the controller only when a second result is ready.
// Reset is synchronous, active low; the point memory needs no clearing.
`timescale 1ns / 1ps

module ransac_multi_line_fit
    import rmlf_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int LINE_LIMIT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pt_in_t      s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output line_res_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int LW = $clog2(LINE_LIMIT + 1);

    rmlf_state_t state_reg, state_next;

    // Control registers.
    logic [CW-1:0]  cnt_reg;
    logic [LW-1:0]  lines_reg;
    logic [9:0]     iter_reg;
    logic [9:0]     iter_cfg_reg;
    logic [15:0]    thr_reg;
    logic [31:0]    lfsr_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  kept_reg;
    logic [CW-1:0]  score_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic           bank_reg;
    logic           out_valid_reg;

    // Payload registers.
    logic [AW-1:0]        i1_reg;
    logic [AW-1:0]        i2_reg;
    logic signed [23:0]   x1_reg, y1_reg, x2_reg, y2_reg, px_reg, py_reg;
    logic signed [40:0]   m_reg;
    logic [39:0]          mmag_reg;
    logic signed [47:0]   c_reg;
    logic [31:0]          tsq_reg;
    logic [112:0]         rhs_reg;
    logic [63:0]          rmag_reg;
    logic signed [40:0]   best_m_reg;
    logic signed [47:0]   best_c_reg;
    line_res_t            pend_reg;
    line_res_t            out_reg;

    // Memories.
    logic [47:0] pt_mem [MAX_POINTS];
    logic        mask_mem [2**(AW+1)];
    logic [47:0] pt_q;
    logic        mask_q;
    logic [AW-1:0] pt_raddr, pt_waddr;
    logic [47:0]   pt_wdata;
    logic          pt_we;
    logic          mask_we;

    // Arithmetic units.
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_dividend, div_quo;
    logic [DIV_DW-1:0] div_divisor, div_rem;
    logic              mul_start, mul_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_prod;

    // Combinational datapath values.
    logic               s_accept;
    logic [31:0]        lfsr_step;
    logic signed [24:0] dy_s, dx_s;
    logic [24:0]        dy_abs, dx_abs;
    logic signed [40:0] m_calc;
    logic [55:0]        mx1_q;
    logic signed [57:0] y1_sh, mx1_s, c_full;
    logic signed [47:0] c_calc;
    logic signed [65:0] ys_s, mx_s, cs_s, r_s;
    logic [65:0]        r_abs;
    logic [112:0]       rhs_calc;
    logic               inl;
    logic               idx_last;
    line_res_t          pend_none;
    line_res_t          pend_line;

    assign s_accept = s_valid && s_ready;
    assign idx_last = (idx_reg + 1'b1) == cnt_reg;

    rmlf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rmlf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Line arithmetic: slope sign, intercept, residual and threshold bound.
    always_comb begin
        lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
        dy_s   = {y2_reg[23], y2_reg} - {y1_reg[23], y1_reg};
        dx_s   = {x2_reg[23], x2_reg} - {x1_reg[23], x1_reg};
        dy_abs = dy_s[24] ? 25'(-dy_s) : 25'(dy_s);
        dx_abs = dx_s[24] ? 25'(-dx_s) : 25'(dx_s);
        m_calc = (dy_s[24] ^ dx_s[24]) ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

        mx1_q  = mul_prod[63:8];
        mx1_s  = (m_reg[40] ^ x1_reg[23]) ? -$signed({2'b0, mx1_q}) : $signed({2'b0, mx1_q});
        y1_sh  = $signed({{26{y1_reg[23]}}, y1_reg, 8'b0});
        c_full = y1_sh - mx1_s;
        if (c_full[57:47] != {11{c_full[57]}}) begin
            c_calc = c_full[57] ? S48_MIN : S48_MAX;
        end else begin
            c_calc = c_full[47:0];
        end

        ys_s  = $signed({{26{py_reg[23]}}, py_reg, 16'b0});
        mx_s  = (m_reg[40] ^ px_reg[23]) ? -$signed({2'b0, mul_prod[63:0]})
                                         : $signed({2'b0, mul_prod[63:0]});
        cs_s  = $signed({{10{c_reg[47]}}, c_reg, 8'b0});
        r_s   = ys_s - mx_s - cs_s;
        r_abs = r_s[65] ? 66'(-r_s) : 66'(r_s);

        rhs_calc = mul_prod[112:0] + {49'b0, tsq_reg, 32'b0};
        inl      = mul_prod < {15'b0, rhs_reg};

        pend_none.line_slope       = '0;
        pend_none.line_intercept   = '0;
        pend_none.line_number      = 3'(lines_reg);
        pend_none.line_found       = 1'b0;
        pend_none.remaining_points = 9'(cnt_reg);
        pend_none.last_result      = 1'b1;

        pend_line.line_slope       = {{7{best_m_reg[40]}}, best_m_reg};
        pend_line.line_intercept   = best_c_reg;
        pend_line.line_number      = 3'(lines_reg);
        pend_line.line_found       = 1'b1;
        pend_line.remaining_points = 9'(kept_reg);
        pend_line.last_result      = (kept_reg == '0) ||
                                     (LW'(lines_reg + 1'b1) == LW'(LINE_LIMIT));
    end

    // Unit operands follow the controller state.
    always_comb begin
        div_dividend = {8'b0, lfsr_step};
        div_divisor  = DIV_DW'(cnt_reg);
        mul_a        = {24'b0, mmag_reg};
        mul_b        = {40'b0, abs24(px_reg)};
        case (state_reg)
            ST_SLOPE: begin
                div_dividend = {dy_abs[23:0], 16'b0};
                div_divisor  = dx_abs[23:0];
            end
            ST_ICPT: begin
                mul_b = {40'b0, abs24(x1_reg)};
            end
            ST_MT: begin
                mul_b = {48'b0, thr_reg};
            end
            ST_RHS: begin
                mul_a = mul_prod[63:0];
                mul_b = mul_prod[63:0];
            end
            ST_SC_SQ: begin
                mul_a = rmag_reg;
                mul_b = rmag_reg;
            end
            default: begin
            end
        endcase
    end

    // Next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        pt_we      = 1'b0;
        pt_waddr   = kept_reg[AW-1:0];
        pt_wdata   = pt_q;
        mask_we    = 1'b0;
        pt_raddr   = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept) begin
                    pt_we    = cnt_reg < CW'(MAX_POINTS);
                    pt_waddr = cnt_reg[AW-1:0];
                    pt_wdata = {s_data.point_y, s_data.point_x};
                    if (s_data.last_point) begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: state_next = (cnt_reg == '0) ? ST_EMIT : ST_ITER;
            ST_ITER: begin
                if (iter_reg < iter_cfg_reg) begin
                    state_next = ST_IDX1;
                end else if (best_cnt_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CMP_RD;
                end
            end
            ST_IDX1: begin
                div_start  = 1'b1;
                state_next = ST_IDX1_W;
            end
            ST_IDX1_W: if (div_done) state_next = ST_IDX2;
            ST_IDX2: begin
                div_start  = 1'b1;
                state_next = ST_IDX2_W;
            end
            ST_IDX2_W: begin
                if (div_done) begin
                    state_next = (div_rem[AW-1:0] == i1_reg) ? ST_SKIP : ST_RD1;
                end
            end
            ST_SKIP: state_next = ST_ITER;
            ST_RD1: begin
                pt_raddr   = i1_reg;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                pt_raddr   = i2_reg;
                state_next = ST_RD3;
            end
            ST_RD3: state_next = ST_SLOPE;
            ST_SLOPE: begin
                if (x1_reg == x2_reg) begin
                    state_next = ST_SKIP;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_SLOPE_W;
                end
            end
            ST_SLOPE_W: if (div_done) state_next = ST_ICPT;
            ST_ICPT: begin
                mul_start  = 1'b1;
                state_next = ST_ICPT_W;
            end
            ST_ICPT_W: if (mul_done) state_next = ST_MT;
            ST_MT: begin
                mul_start  = 1'b1;
                state_next = ST_MT_W;
            end
            ST_MT_W: if (mul_done) state_next = ST_RHS;
            ST_RHS: begin
                mul_start  = 1'b1;
                state_next = ST_RHS_W;
            end
            ST_RHS_W: if (mul_done) state_next = ST_SC_RD;
            ST_SC_RD: state_next = ST_SC_LAT;
            ST_SC_LAT: state_next = ST_SC_MX;
            ST_SC_MX: begin
                mul_start  = 1'b1;
                state_next = ST_SC_MX_W;
            end
            ST_SC_MX_W: if (mul_done) state_next = ST_SC_SQ;
            ST_SC_SQ: begin
                mul_start  = 1'b1;
                state_next = ST_SC_SQ_W;
            end
            ST_SC_SQ_W: begin
                if (mul_done) begin
                    mask_we    = 1'b1;
                    state_next = idx_last ? ST_SC_END : ST_SC_RD;
                end
            end
            ST_SC_END: state_next = ST_ITER;
            ST_CMP_RD: state_next = ST_CMP_WR;
            ST_CMP_WR: begin
                pt_we      = !mask_q;
                state_next = idx_last ? ST_CMP_END : ST_CMP_RD;
            end
            ST_CMP_END: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = pend_reg.last_result ? ST_IDLE : ST_SEARCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers, configuration and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            lines_reg     <= '0;
            iter_reg      <= '0;
            iter_cfg_reg  <= ITER_RESET;
            thr_reg       <= THR_RESET;
            lfsr_reg      <= SEED_RESET;
            idx_reg       <= '0;
            kept_reg      <= '0;
            score_reg     <= '0;
            best_cnt_reg  <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_reg      <= cfg_data[15:0];
                    REG_ITERATIONS: iter_cfg_reg <= cfg_data[9:0];
                    REG_SEED:       lfsr_reg     <= cfg_data;
                    default: begin
                    end
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (cnt_reg < CW'(MAX_POINTS)) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        lines_reg <= '0;
                    end
                end
                ST_SEARCH: begin
                    iter_reg     <= '0;
                    best_cnt_reg <= '0;
                end
                ST_IDX1, ST_IDX2: lfsr_reg <= lfsr_step;
                ST_SKIP: iter_reg <= iter_reg + 1'b1;
                ST_RHS_W: begin
                    idx_reg   <= '0;
                    score_reg <= '0;
                end
                ST_SC_SQ_W: begin
                    if (mul_done) begin
                        idx_reg   <= idx_reg + 1'b1;
                        score_reg <= score_reg + CW'(inl);
                    end
                end
                ST_SC_END: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (score_reg > best_cnt_reg) begin
                        best_cnt_reg <= score_reg;
                        bank_reg     <= !bank_reg;
                    end
                end
                ST_ITER: begin
                    idx_reg  <= '0;
                    kept_reg <= '0;
                end
                ST_CMP_WR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!mask_q) begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                ST_CMP_END: cnt_reg <= kept_reg;
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        if (pend_reg.last_result) begin
                            cnt_reg <= '0;
                        end else begin
                            lines_reg <= lines_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the candidate and scoring datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SEARCH: begin
                best_m_reg <= '0;
                best_c_reg <= '0;
                pend_reg   <= pend_none;
            end
            ST_ITER: pend_reg <= pend_none;
            ST_IDX1_W: if (div_done) i1_reg <= div_rem[AW-1:0];
            ST_IDX2_W: if (div_done) i2_reg <= div_rem[AW-1:0];
            ST_RD2: begin
                x1_reg <= pt_q[23:0];
                y1_reg <= pt_q[47:24];
            end
            ST_RD3: begin
                x2_reg <= pt_q[23:0];
                y2_reg <= pt_q[47:24];
            end
            ST_SLOPE_W: begin
                if (div_done) begin
                    m_reg    <= m_calc;
                    mmag_reg <= div_quo;
                end
            end
            ST_ICPT_W: if (mul_done) c_reg <= c_calc;
            ST_MT: tsq_reg <= thr_reg * thr_reg;
            ST_RHS_W: if (mul_done) rhs_reg <= rhs_calc;
            ST_SC_LAT: begin
                px_reg <= pt_q[23:0];
                py_reg <= pt_q[47:24];
            end
            ST_SC_MX_W: if (mul_done) rmag_reg <= r_abs[63:0];
            ST_SC_END: begin
                if (score_reg > best_cnt_reg) begin
                    best_m_reg <= m_reg;
                    best_c_reg <= c_reg;
                end
            end
            ST_CMP_END: pend_reg <= pend_line;
            ST_EMIT: if (!out_valid_reg || m_ready) out_reg <= pend_reg;
            default: begin
            end
        endcase
    end

    // Point memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_q <= pt_mem[pt_raddr];
    end

    // Inlier masks: the bank not holding the best model takes the current scores.
    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[{!bank_reg, idx_reg[AW-1:0]}] <= inl;
        end
        mask_q <= mask_mem[{bank_reg, idx_reg[AW-1:0]}];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // The stored count never passes the memory depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count exceeds memory depth");

    // The best model cannot own more inliers than there are points.
    a_best_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ITER) |-> (best_cnt_reg <= cnt_reg))
        else $error("best inlier count exceeds point count");

    // Compaction never writes ahead of the entry being read.
    a_kept_le_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP_WR) |-> (kept_reg <= idx_reg))
        else $error("compaction write overtakes read");

    // A new search only starts below the line limit.
    a_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (lines_reg < LW'(LINE_LIMIT)))
        else $error("line search started past the limit");

    // Equal index pairs are never fetched as a candidate.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD1) |-> (i1_reg != i2_reg))
        else $error("candidate pair uses one point twice");

endmodule
